// ===== rtl/core/vsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared constants and types for the voxel statistics accumulator.
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = 12;
    localparam int POS_W       = 24;
    localparam int RES_W       = 16;
    localparam int CNT_W       = 16;
    localparam int SUM_W       = 40;
    localparam int MOM_W       = 64;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [MOM_W-1:0] MOMENT_ONE = 64'd65536;

    // Configuration register indexes.
    localparam logic [2:0] REG_RES_X    = 3'd0;
    localparam logic [2:0] REG_RES_Y    = 3'd1;
    localparam logic [2:0] REG_RES_Z    = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd5;
    localparam logic [2:0] REG_MIN_PTS  = 3'd6;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic              num_neg;
        logic [SUM_W-1:0]  num_mag;
        logic [RES_W-1:0]  den;
        logic              floor_mode;
    } div_req_t;

    // Result from the shared divider.
    typedef struct packed {
        logic                done;
        logic signed [SUM_W:0] quot;
    } div_rsp_t;

endpackage

// ===== rtl/core/vsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module vsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read before write: a write cycle returns the old contents of the entry.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/vsa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_div
// Sequential restoring divider, one quotient bit per cycle.
// Divides a signed magnitude by an unsigned 16-bit divisor, truncating or
// flooring.
// ----------------------------------------------------------------------------
module vsa_div
    import vsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [RES_W:0]    rem_reg, rem_next;
    logic [RES_W-1:0]  den_reg;
    logic              neg_reg, floor_reg;
    logic [RES_W:0]    trial;
    logic [SUM_W:0]    qext;
    logic              done_flag_reg;

    // One shift-subtract step per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg[RES_W-1:0], quo_reg[SUM_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            quo_next  = req.num_mag;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (req.start)
        begin
            den_reg   <= req.den;
            neg_reg   <= req.num_neg;
            floor_reg <= req.floor_mode;
        end
    end

    // Apply sign; floor rounds a negative inexact quotient down.
    always_comb
    begin
        qext     = {1'b0, quo_reg};
        rsp.quot = neg_reg ? -$signed(qext) : $signed(qext);
        if (neg_reg && floor_reg && (rem_reg != '0))
        begin
            rsp.quot = rsp.quot - (SUM_W+1)'(1);
        end
        rsp.done = ~busy_reg & done_flag_reg;
    end

    // Completion is flagged with a one-cycle strobe once the last step has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_flag_reg <= 1'b0;
        end
        else
        begin
            done_flag_reg <= busy_reg && (step_reg == STEP_W'(1)) && !req.start;
        end
    end

endmodule

// ===== rtl/core/voxel_statistics_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_statistics_accumulator
// Bins points into voxels and accumulates count, sums and moments per voxel.
// ----------------------------------------------------------------------------
// Sequence: busy stays high while an accepted point inside the grid runs
// three binning divisions, six moment updates and three centroid divisions,
// while a point outside the grid runs only the binning divisions and a zero
// resolution none. The result is strobed in the following cycle, in which
// the next point can be accepted. One point at a time. The receiver cannot
// stall results. Reset: registers take their reset values, then a clearing
// pass over all 4096 entries zeroes the count memory while busy stays high.
module voxel_statistics_accumulator
    import vsa_pkg::*;
#(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16,
    parameter int GRID_Z = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [POS_W-1:0]        cfg_data,
    output logic                    done,
    output logic [ADDR_W-1:0]       cell_index,
    output logic [CNT_W-1:0]        cell_points,
    output logic signed [POS_W-1:0] mean_x,
    output logic signed [POS_W-1:0] mean_y,
    output logic signed [POS_W-1:0] mean_z,
    output logic                    enough,
    output logic                    outside
);

    localparam int GX_W = $clog2(GRID_X + 1);
    localparam int GY_W = $clog2(GRID_Y + 1);
    localparam int GZ_W = $clog2(GRID_Z + 1);
    localparam int LIN_W = GX_W + GY_W + GZ_W + ADDR_W;

    // Sequencer codes.
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_WAIT   = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_READ   = 4'd5;
    localparam logic [3:0] S_MOMRD  = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_MOMWR  = 4'd8;
    localparam logic [3:0] S_MEAN   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;

    // Configuration registers.
    logic [RES_W-1:0]        res_reg [3];
    logic signed [POS_W-1:0] org_reg [3];
    logic [CNT_W-1:0]        min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg[0] <= 16'd256;
            res_reg[1] <= 16'd256;
            res_reg[2] <= 16'd256;
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            min_reg    <= 16'd6;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RES_X:    res_reg[0] <= cfg_data[RES_W-1:0];
                REG_RES_Y:    res_reg[1] <= cfg_data[RES_W-1:0];
                REG_RES_Z:    res_reg[2] <= cfg_data[RES_W-1:0];
                REG_ORIGIN_X: org_reg[0] <= cfg_data;
                REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                REG_MIN_PTS:  min_reg    <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Point, working registers.
    logic signed [POS_W-1:0] pos_reg [3];
    logic signed [SUM_W:0]   cell_reg [3];
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [POS_W-1:0] mean_reg [3];
    logic [1:0]              axis_reg;
    logic                    phase_reg;   // 0: binning, 1: centroid
    logic [ADDR_W-1:0]       clr_reg;
    logic [ADDR_W-1:0]       lin_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    first_reg;
    logic                    acc_reg;
    logic [2:0]              mom_reg;
    logic signed [MOM_W-1:0] prod_reg;
    logic                    out_reg;
    logic                    done_reg;

    // Divider.
    div_req_t dreq;
    div_rsp_t drsp;
    logic signed [SUM_W-1:0] dnum;

    vsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        dnum = phase_reg ? sum_reg[axis_reg]
                         : SUM_W'(pos_reg[axis_reg]);
        dreq.start      = (state_reg == S_DIV);
        dreq.num_neg    = dnum[SUM_W-1];
        dreq.num_mag    = dnum[SUM_W-1] ? -dnum : dnum;
        dreq.den        = phase_reg ? cnt_reg : res_reg[axis_reg];
        dreq.floor_mode = !phase_reg;
    end

    // Memories.
    logic              cnt_we, sum_we, mom_we;
    logic [ADDR_W-1:0] cnt_addr;
    logic [CNT_W-1:0]  cnt_wd, cnt_rd;
    logic [SUM_W-1:0]  sum_wd [3];
    logic [SUM_W-1:0]  sum_rd [3];
    logic [ADDR_W+2:0] mom_addr;
    logic [MOM_W-1:0]  mom_wd, mom_rd;

    assign cnt_addr = (state_reg == S_CLEAR) ? clr_reg : lin_reg;

    vsa_ram #(.WIDTH(CNT_W), .DEPTH(STORE_DEPTH)) u_cnt (
        .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wd), .rdata(cnt_rd)
    );

    for (genvar g = 0; g < 3; g++)
    begin : g_sum
        vsa_ram #(.WIDTH(SUM_W), .DEPTH(STORE_DEPTH)) u_sum (
            .clk(clk), .we(sum_we), .addr(lin_reg), .wdata(sum_wd[g]),
            .rdata(sum_rd[g])
        );
        assign sum_wd[g] = sum_reg[g];
    end

    vsa_ram #(.WIDTH(MOM_W), .DEPTH(STORE_DEPTH * 8)) u_mom (
        .clk(clk), .we(mom_we), .addr(mom_addr), .wdata(mom_wd), .rdata(mom_rd)
    );

    assign mom_addr = {lin_reg, mom_reg};

    // Moment operands and identity start.
    logic [1:0] ma, mb;
    always_comb
    begin
        unique case (mom_reg)
            3'd0:    begin ma = 2'd0; mb = 2'd0; end
            3'd1:    begin ma = 2'd0; mb = 2'd1; end
            3'd2:    begin ma = 2'd0; mb = 2'd2; end
            3'd3:    begin ma = 2'd1; mb = 2'd1; end
            3'd4:    begin ma = 2'd1; mb = 2'd2; end
            default: begin ma = 2'd2; mb = 2'd2; end
        endcase
    end

    // Coordinate product at the natural 24 x 24 width.
    logic signed [2*POS_W-1:0] prod_full;
    assign prod_full = pos_reg[ma] * pos_reg[mb];

    logic [MOM_W-1:0] mom_base;
    always_comb
    begin
        if (first_reg)
        begin
            mom_base = (mom_reg == 3'd0 || mom_reg == 3'd3 || mom_reg == 3'd5)
                       ? MOMENT_ONE : '0;
        end
        else
        begin
            mom_base = mom_rd;
        end
        mom_wd = mom_base + prod_reg;
    end

    // Grid check on the binned coordinates.
    logic signed [SUM_W:0] rel [3];
    logic                  in_grid;
    logic [LIN_W-1:0]      lin_full;
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            rel[a] = cell_reg[a] - (SUM_W+1)'(org_reg[a]);
        end
        in_grid = !rel[0][SUM_W] && (rel[0] < (SUM_W+1)'(GRID_X)) &&
                  !rel[1][SUM_W] && (rel[1] < (SUM_W+1)'(GRID_Y)) &&
                  !rel[2][SUM_W] && (rel[2] < (SUM_W+1)'(GRID_Z)) &&
                  (res_reg[0] != '0) && (res_reg[1] != '0) && (res_reg[2] != '0);
        lin_full = LIN_W'(rel[0][GX_W-1:0])
                 + LIN_W'(rel[1][GY_W-1:0]) * LIN_W'(GRID_X)
                 + LIN_W'(rel[2][GZ_W-1:0]) * LIN_W'(GRID_X * GRID_Y);
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_we = 1'b0;
        sum_we = 1'b0;
        mom_we = 1'b0;
        cnt_wd = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we = 1'b1;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (res_reg[0] == '0 || res_reg[1] == '0 ||
                                  res_reg[2] == '0) ? S_OUT : S_DIV;
                end
            end
            S_DIV:   state_next = S_WAIT;
            S_WAIT:
            begin
                if (drsp.done)
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_next = phase_reg ? S_OUT : S_CHECK;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_CHECK:
            begin
                state_next = (in_grid && lin_full < LIN_W'(STORE_DEPTH)) ? S_READ
                                                                         : S_OUT;
            end
            S_READ:  state_next = S_MOMRD;
            S_MOMRD: state_next = S_MUL;
            S_MUL:   state_next = S_MOMWR;
            S_MOMWR:
            begin
                mom_we = acc_reg;
                state_next = (mom_reg == 3'd5) ? S_MEAN : S_MOMRD;
            end
            S_MEAN:
            begin
                cnt_we = acc_reg;
                sum_we = acc_reg;
                cnt_wd = cnt_reg;
                state_next = S_DIV;
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            done_reg <= (state_reg == S_OUT);
        end
    end

    // Datapath updates.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                pos_reg[0] <= pos_x;
                pos_reg[1] <= pos_y;
                pos_reg[2] <= pos_z;
                axis_reg   <= 2'd0;
                phase_reg  <= 1'b0;
                out_reg    <= 1'b1;
            end
            S_WAIT:
            begin
                if (drsp.done)
                begin
                    if (phase_reg)
                    begin
                        mean_reg[axis_reg] <= drsp.quot[POS_W-1:0];
                    end
                    else
                    begin
                        cell_reg[axis_reg] <= drsp.quot;
                    end
                    axis_reg <= axis_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                lin_reg <= lin_full[ADDR_W-1:0];
                mom_reg <= 3'd0;
            end
            S_MOMRD:
            begin
                if (mom_reg == 3'd0)
                begin
                    first_reg <= (cnt_rd == '0);
                    acc_reg   <= (cnt_rd != COUNT_MAX);
                    cnt_reg   <= (cnt_rd != COUNT_MAX) ? cnt_rd + 1'b1 : cnt_rd;
                    for (int a = 0; a < 3; a++)
                    begin
                        sum_reg[a] <= (cnt_rd == '0) ? SUM_W'(pos_reg[a])
                                    : (cnt_rd != COUNT_MAX)
                                      ? sum_rd[a] + SUM_W'(pos_reg[a]) : sum_rd[a];
                    end
                end
            end
            S_MUL:
            begin
                prod_reg <= MOM_W'(prod_full);
            end
            S_MOMWR:
            begin
                mom_reg <= mom_reg + 1'b1;
            end
            S_MEAN:
            begin
                axis_reg  <= 2'd0;
                phase_reg <= 1'b1;
                out_reg   <= 1'b0;
            end
            default: ;
        endcase
    end

    // Result strobe: zero fields for points outside the grid.
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign outside     = done_reg & out_reg;
    assign cell_index  = out_reg ? '0 : lin_reg;
    assign cell_points = out_reg ? '0 : cnt_reg;
    assign mean_x      = out_reg ? '0 : mean_reg[0];
    assign mean_y      = out_reg ? '0 : mean_reg[1];
    assign mean_z      = out_reg ? '0 : mean_reg[2];
    assign enough      = !out_reg && (cnt_reg >= min_reg);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the voxel statistics accumulator. Points are
// sent one transaction at a time under several register settings and idle
// patterns; a local voxel store predicts index, count, centroid and flags,
// and every result strobe is compared with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import vsa_pkg::*;

    localparam int GX         = 16;
    localparam int GY         = 16;
    localparam int GZ         = 16;
    localparam int DRAIN      = 400;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [ADDR_W-1:0]       idx;
        logic [CNT_W-1:0]        pts;
        logic signed [POS_W-1:0] mx;
        logic signed [POS_W-1:0] my;
        logic signed [POS_W-1:0] mz;
        logic                    enough;
        logic                    outside;
    } voxel_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [2:0]              cfg_index;
    logic [POS_W-1:0]        cfg_data;
    logic                    done;
    logic [ADDR_W-1:0]       cell_index;
    logic [CNT_W-1:0]        cell_points;
    logic signed [POS_W-1:0] mean_x;
    logic signed [POS_W-1:0] mean_y;
    logic signed [POS_W-1:0] mean_z;
    logic                    enough;
    logic                    outside;

    // Predictor state: registers and per-voxel count and coordinate sums.
    longint        res_v [3];
    longint        org_v [3];
    longint        min_pts;
    int unsigned   voxel_count [STORE_DEPTH];
    longint        voxel_sum [STORE_DEPTH][3];

    voxel_result_t pending_results [$];
    int            mismatches;
    int            idle_pct;
    longint        cycles;

    voxel_statistics_accumulator #(
        .GRID_X(GX),
        .GRID_Y(GY),
        .GRID_Z(GZ)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .done(done),
        .cell_index(cell_index),
        .cell_points(cell_points),
        .mean_x(mean_x),
        .mean_y(mean_y),
        .mean_z(mean_z),
        .enough(enough),
        .outside(outside)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // Bin one point, update the voxel store and return the expected result.
    function automatic voxel_result_t bin_point(longint p [3]);
        voxel_result_t r;
        longint        c [3];
        longint        lin;
        int unsigned   n;
        r = '0;
        if (res_v[0] == 0 || res_v[1] == 0 || res_v[2] == 0)
        begin
            r.outside = 1'b1;
            return r;
        end
        for (int a = 0; a < 3; a++)
            c[a] = floor_quot(p[a], res_v[a]) - org_v[a];
        if (c[0] < 0 || c[0] >= GX || c[1] < 0 || c[1] >= GY || c[2] < 0 || c[2] >= GZ)
        begin
            r.outside = 1'b1;
            return r;
        end
        lin = c[0] + c[1] * GX + c[2] * GX * GY;
        if (lin >= STORE_DEPTH)
        begin
            r.outside = 1'b1;
            return r;
        end
        n = voxel_count[lin];
        if (n == 0)
        begin
            for (int a = 0; a < 3; a++)
                voxel_sum[lin][a] = 0;
        end
        if (n < COUNT_MAX)
        begin
            n = n + 1;
            voxel_count[lin] = n;
            for (int a = 0; a < 3; a++)
                voxel_sum[lin][a] = voxel_sum[lin][a] + p[a];
        end
        r.idx    = lin[ADDR_W-1:0];
        r.pts    = n[CNT_W-1:0];
        r.mx     = POS_W'(voxel_sum[lin][0] / longint'(n));
        r.my     = POS_W'(voxel_sum[lin][1] / longint'(n));
        r.mz     = POS_W'(voxel_sum[lin][2] / longint'(n));
        r.enough = (longint'(n) >= min_pts);
        return r;
    endfunction

    // Result checker: every strobe is matched against the oldest prediction.
    always @(posedge clk)
    begin
        voxel_result_t got;
        voxel_result_t exp_r;
        if (rst_n && done)
        begin
            got = '{cell_index, cell_points, mean_x, mean_y, mean_z, enough, outside};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: %p", got);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.idx !== exp_r.idx || got.pts !== exp_r.pts ||
                    got.mx !== exp_r.mx || got.my !== exp_r.my || got.mz !== exp_r.mz ||
                    got.enough !== exp_r.enough || got.outside !== exp_r.outside)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, actual %p", exp_r, got);
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one point, after a random number of idle cycles.
    task automatic send_point(longint x, longint y, longint z);
        longint p [3];
        p[0] = x;
        p[1] = y;
        p[2] = z;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        pos_x <= POS_W'(x);
        pos_y <= POS_W'(y);
        pos_z <= POS_W'(z);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        pending_results = {pending_results, bin_point(p)};
    endtask

    // Hold off until every pending result has arrived and the block is quiet.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // One register write transaction; the block must be idle.
    task automatic write_reg(logic [2:0] idx, longint value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= POS_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_RES_X:    res_v[0] = value & 16'hFFFF;
            REG_RES_Y:    res_v[1] = value & 16'hFFFF;
            REG_RES_Z:    res_v[2] = value & 16'hFFFF;
            REG_ORIGIN_X: org_v[0] = longint'($signed(POS_W'(value)));
            REG_ORIGIN_Y: org_v[1] = longint'($signed(POS_W'(value)));
            REG_ORIGIN_Z: org_v[2] = longint'($signed(POS_W'(value)));
            REG_MIN_PTS:  min_pts  = value & 16'hFFFF;
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(longint r, longint o, longint m);
        write_reg(REG_RES_X, r);
        write_reg(REG_RES_Y, r);
        write_reg(REG_RES_Z, r);
        write_reg(REG_ORIGIN_X, o);
        write_reg(REG_ORIGIN_Y, o);
        write_reg(REG_ORIGIN_Z, o);
        write_reg(REG_MIN_PTS, m);
    endtask

    // Random coordinate on one axis: mostly inside the grid.
    function automatic longint pick_coord(int a, int hot);
        longint v;
        if (hot != 0 && res_v[a] != 0)
        begin
            v = (org_v[a] + $urandom_range(GX - 1)) * res_v[a] +
                $urandom_range(res_v[a] - 1);
            if (v >= -(1 << 23) && v < (1 << 23))
                return v;
        end
        return longint'($signed(POS_W'($urandom)));
    endfunction

    task automatic test_random(int n, int pct);
        int hot;
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            hot = ($urandom_range(99) < 85);
            send_point(pick_coord(0, hot), pick_coord(1, hot), pick_coord(2, hot));
        end
        idle_pct = 0;
    endtask

    // Grid corners, the 24-bit extremes and a voxel filled past the minimum.
    task automatic test_directed();
        send_point(0, 0, 0);
        send_point(4095, 4095, 4095);
        send_point(4096, 0, 0);
        send_point(0, -1, 0);
        send_point(-8388608, -8388608, -8388608);
        send_point(8388607, 8388607, 8388607);
        send_point(255, 256, 511);
        for (int i = 0; i < 7; i++)
            send_point(100 + i * 20, 30 * i, 250 - i);
    endtask

    // Zero resolution on each axis in turn makes every point outside.
    task automatic test_zero_resolution();
        for (int a = 0; a < 3; a++)
        begin
            write_reg(REG_RES_X + 3'(a), 0);
            send_point(10, 10, 10);
            write_reg(REG_RES_X + 3'(a), 256);
        end
    endtask

    // Minimum of zero, of all ones and of one.
    task automatic test_min_thresholds();
        write_reg(REG_MIN_PTS, 0);
        send_point(777, 1500, 3000);
        write_reg(REG_MIN_PTS, 65535);
        send_point(777, 1500, 3000);
        write_reg(REG_MIN_PTS, 1);
        send_point(900, 3900, 12);
    endtask

    // Extreme origins: the lowest reachable grid and one at the highest coordinate.
    task automatic test_origin_extremes();
        set_grid(1, -8388608, 3);
        send_point(-8388608, -8388608, -8388608);
        send_point(-8388593, -8388600, -8388608);
        send_point(-8388592, -8388608, -8388608);
        write_reg(REG_ORIGIN_X, 8388607);
        send_point(8388607, -8388608, -8388608);
        set_grid(65535, -128, 2);
        send_point(-8388608, -8388608, 8388607);
        send_point(8388607, 0, -1);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        pos_x     = '0;
        pos_y     = '0;
        pos_z     = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_RES_X;
        cfg_data  = '0;
        mismatches = 0;
        idle_pct  = 0;
        cycles    = 0;
        res_v     = '{256, 256, 256};
        org_v     = '{0, 0, 0};
        min_pts   = 6;
        for (int i = 0; i < STORE_DEPTH; i++)
            voxel_count[i] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_zero_resolution();
        test_min_thresholds();
        test_origin_extremes();

        set_grid(256, 0, 6);
        test_random(300, 0);
        wait_idle();
        test_random(250, 84);
        set_grid(1, -8, 4);
        test_random(250, 25);
        set_grid(65535, -128, 65535);
        test_random(150, 84);
        set_grid(37, -5, 1);
        write_reg(REG_RES_Y, 1000);
        write_reg(REG_ORIGIN_Z, 3);
        test_random(370, 0);

        wait_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/vsa_pkg.sv
rtl/core/vsa_ram.sv
rtl/core/vsa_div.sv
rtl/core/voxel_statistics_accumulator.sv
tb/sv/tb_top.sv
